>>> hw/rtl/biou_pkg.sv
`timescale 1ns / 1ps
package biou_pkg;
   localparam int MaxBoxes         = 256;
   localparam int CoordBitsDefault = 16;
   localparam int RegBits          = 17;
   localparam int FracBits         = 16;
   localparam logic [RegBits-1:0] OneQ16       = 17'd65536;
   localparam logic [RegBits-1:0] ThreshReset  = 17'd45875;
   localparam logic [RegBits-1:0] GainReset    = 17'd19661;
   localparam logic CsrThreshIdx = 1'b0;
   localparam logic CsrGainIdx   = 1'b1;
   localparam logic KindStore    = 1'b0;
   localparam logic KindScore    = 1'b1;
endpackage

>>> hw/rtl/box_iou_3d_with_containment.sv
`timescale 1ns / 1ps
// Axis-aligned 3D box IoU scorer with containment bonus.
// Input channel req_*: kind 0 stores the box corners in slot req_box_slot;
// kind 1 scores the boxes in slots req_first_index and req_second_index.
// A store gives no result; a score gives one rsp_overlap_score (Q1.16).
// Configuration: csr_we with csr_index 0 (threshold) or 1 (gain).
// The pipeline takes one item per cycle while not stalled. A score passes a table read stage,
// an overlap stage, two volume multiply stages, a union stage, seventeen
// divider stages (one quotient bit each), a bonus multiply stage and a
// saturation stage: 24 register stages.
// Throughput is set by the pipeline: one item per cycle with no bubbles unless stalled.
// The whole pipe advances together; when rsp_ready is low and the output
// holds a result, everything stalls and req_ready drops. Nothing is lost.
// Reset clears valid bits and the threshold and gain registers; the box table is not cleared,
// and reading an unwritten slot gives an undefined score.
// A store writes the table at acceptance, so a following score sees it.
module box_iou_3d_with_containment import biou_pkg::*; #(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [7:0]                   req_box_slot,
   input  logic signed [COORD_BITS-1:0] req_min_x,
   input  logic signed [COORD_BITS-1:0] req_min_y,
   input  logic signed [COORD_BITS-1:0] req_min_z,
   input  logic signed [COORD_BITS-1:0] req_max_x,
   input  logic signed [COORD_BITS-1:0] req_max_y,
   input  logic signed [COORD_BITS-1:0] req_max_z,
   input  logic [7:0]                   req_first_index,
   input  logic [7:0]                   req_second_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [RegBits-1:0]           rsp_overlap_score,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [RegBits-1:0]           csr_wdata
);
   localparam int AW = $clog2(MaxBoxes);
   localparam int EB = COORD_BITS + 1;          // extent bits
   localparam int VB = 3 * EB;                  // volume bits
   localparam int UB = VB + 1;
   localparam int DivLat = FracBits + 1;
   localparam int Depth = 5 + DivLat + 2;

   logic [RegBits-1:0] thresh_ff, gain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ThreshReset;
         gain_ff   <= GainReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrThreshIdx: thresh_ff <= csr_wdata;
            CsrGainIdx:   gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline valid bits; adv moves every stage at once.
   logic [Depth-1:0] vld_ff;
   logic adv;
   assign adv = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = adv;
   logic acc, score_in;
   assign acc = req_valid && req_ready;
   assign score_in = acc && (req_kind == KindScore);
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Depth-2:0], score_in};
   end

   // Two copies of the table give two read ports.
   logic [6*COORD_BITS-1:0] tab_a [MaxBoxes];
   logic [6*COORD_BITS-1:0] tab_b [MaxBoxes];
   logic [6*COORD_BITS-1:0] ba_ff, bb_ff;
   logic [AW-1:0] wa, ra, rb;
   assign wa = req_box_slot[AW-1:0];
   assign ra = req_first_index[AW-1:0];
   assign rb = req_second_index[AW-1:0];
   always_ff @(posedge clock) begin
      if (acc && req_kind == KindStore) begin
         tab_a[wa] <= {req_max_z, req_max_y, req_max_x, req_min_z, req_min_y, req_min_x};
         tab_b[wa] <= {req_max_z, req_max_y, req_max_x, req_min_z, req_min_y, req_min_x};
      end
      if (adv) begin
         ba_ff <= tab_a[ra];
         bb_ff <= tab_b[rb];
      end
   end

   // Stage 2: extents.
   logic [EB-1:0] ie_ff [3], ea_ff [3], eb_ff [3];
   logic empty_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [COORD_BITS-1:0] alo, ahi, blo, bhi, lo, hi;
         logic e;
         e = 1'b0;
         for (int k = 0; k < 3; k++) begin
            alo = ba_ff[k*COORD_BITS +: COORD_BITS];
            ahi = ba_ff[(k+3)*COORD_BITS +: COORD_BITS];
            blo = bb_ff[k*COORD_BITS +: COORD_BITS];
            bhi = bb_ff[(k+3)*COORD_BITS +: COORD_BITS];
            lo = (alo > blo) ? alo : blo;
            hi = (ahi < bhi) ? ahi : bhi;
            if (lo >= hi) e = 1'b1;
            ie_ff[k] <= EB'($signed({hi[COORD_BITS-1], hi}) - $signed({lo[COORD_BITS-1], lo}));
            ea_ff[k] <= EB'($signed({ahi[COORD_BITS-1], ahi}) - $signed({alo[COORD_BITS-1], alo}));
            eb_ff[k] <= EB'($signed({bhi[COORD_BITS-1], bhi}) - $signed({blo[COORD_BITS-1], blo}));
         end
         empty_ff <= e;
      end
   end

   // Stages 3 and 4: volumes. An inverted box always makes the overlap
   // empty, so VB bits carry the exact product wherever the result uses it.
   logic [2*EB-1:0] pi_ff, pa_ff, pb_ff;
   logic [EB-1:0] zi_ff, za_ff, zb_ff;
   logic empty2_ff, empty3_ff;
   logic [VB-1:0] vi_ff, va_ff, vb_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         pi_ff <= ie_ff[0] * ie_ff[1];
         pa_ff <= ea_ff[0] * ea_ff[1];
         pb_ff <= eb_ff[0] * eb_ff[1];
         zi_ff <= ie_ff[2]; za_ff <= ea_ff[2]; zb_ff <= eb_ff[2];
         empty2_ff <= empty_ff;
         vi_ff <= VB'(pi_ff * zi_ff);
         va_ff <= VB'(pa_ff * za_ff);
         vb_ff <= VB'(pb_ff * zb_ff);
         empty3_ff <= empty2_ff;
      end
   end

   // Stage 5: union and smaller volume.
   logic [UB-1:0] uni_ff, sm_ff, int_ff;
   logic zero_ff, nosm_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic [UB-1:0] u;
         u = UB'(va_ff) + UB'(vb_ff) - UB'(vi_ff);
         uni_ff  <= u;
         int_ff  <= UB'(vi_ff);
         sm_ff   <= (va_ff < vb_ff) ? UB'(va_ff) : UB'(vb_ff);
         zero_ff <= empty3_ff || (u == '0);
         nosm_ff <= (va_ff < vb_ff) ? (va_ff == '0) : (vb_ff == '0);
      end
   end

   logic [RegBits-1:0] iou_q, cont_q;
   biou_div #(.VolBits(UB)) u_div_iou (
      .clock(clock), .adv(adv), .num(int_ff),
      .den((uni_ff == '0) ? UB'(1) : uni_ff), .quo(iou_q));
   biou_div #(.VolBits(UB)) u_div_cont (
      .clock(clock), .adv(adv), .num(int_ff),
      .den((sm_ff == '0) ? UB'(1) : sm_ff), .quo(cont_q));

   logic zero_d_ff [DivLat], nosm_d_ff [DivLat];
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_d_ff[0] <= zero_ff;
         nosm_d_ff[0] <= nosm_ff;
         for (int i = 1; i < DivLat; i++) begin
            zero_d_ff[i] <= zero_d_ff[i-1];
            nosm_d_ff[i] <= nosm_d_ff[i-1];
         end
      end
   end

   // Bonus multiply, then add and saturate.
   logic [2*RegBits-1:0] bon_ff;
   logic [RegBits-1:0] iou_ff;
   logic zero2_ff;
   logic [RegBits-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic [RegBits+1:0] s;
         if (!nosm_d_ff[DivLat-1] && cont_q > thresh_ff)
            bon_ff <= gain_ff * (cont_q - thresh_ff);
         else
            bon_ff <= '0;
         iou_ff   <= iou_q;
         zero2_ff <= zero_d_ff[DivLat-1];
         s = {2'b00, iou_ff} + {1'b0, bon_ff[2*RegBits-1:FracBits]};
         if (zero2_ff) out_ff <= '0;
         else if (s > {2'b00, OneQ16}) out_ff <= OneQ16;
         else out_ff <= s[RegBits-1:0];
      end
   end

   assign rsp_valid = vld_ff[Depth-1];
   assign rsp_overlap_score = out_ff;
endmodule

>>> hw/rtl/biou_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: floor(num * 2^16 / den) saturated at 1.0.
// One quotient bit per stage, so a new item can enter every cycle while adv is high.
module biou_div import biou_pkg::*; #(
   parameter int VolBits = 51
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [VolBits-1:0]   num,
   input  logic [VolBits-1:0]   den,
   output logic [RegBits-1:0]   quo
);
   logic [VolBits:0]        rem_ff [FracBits+1];
   logic [VolBits-1:0]      den_ff [FracBits+1];
   logic [FracBits-1:0]     q_ff   [FracBits+1];
   logic                    sat_ff [FracBits+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= {1'b0, num};
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= (num >= den);
         for (int i = 0; i < FracBits; i++) begin
            logic [VolBits+1:0] r2;
            r2 = {rem_ff[i], 1'b0};
            if (r2 >= {2'b00, den_ff[i]}) begin
               rem_ff[i+1] <= (VolBits+1)'(r2 - {2'b00, den_ff[i]});
               q_ff[i+1]   <= {q_ff[i][FracBits-2:0], 1'b1};
            end else begin
               rem_ff[i+1] <= r2[VolBits:0];
               q_ff[i+1]   <= {q_ff[i][FracBits-2:0], 1'b0};
            end
            den_ff[i+1] <= den_ff[i];
            sat_ff[i+1] <= sat_ff[i];
         end
      end
   end
   assign quo = sat_ff[FracBits] ? OneQ16 : {1'b0, q_ff[FracBits]};
endmodule

>>> hw/rtl/biou_checker.sv
`timescale 1ns / 1ps
module biou_checker import biou_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [RegBits-1:0] rsp_overlap_score
);
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_overlap_score <= OneQ16) else $error("score above one");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_overlap_score))
      else $error("result dropped while stalled");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("input taken during stall");
   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("input blocked while output empty");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind box_iou_3d_with_containment biou_checker u_biou_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_overlap_score(rsp_overlap_score));

>>> tb/tb_box_iou_3d_with_containment.sv
`timescale 1ns / 1ps
module tb_box_iou_3d_with_containment;
   import biou_pkg::*;

   localparam int PipeDepth = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = KindStore;
   logic [7:0] req_box_slot = '0;
   logic signed [15:0] req_min_x = '0, req_min_y = '0, req_min_z = '0;
   logic signed [15:0] req_max_x = '0, req_max_y = '0, req_max_z = '0;
   logic [7:0] req_first_index = '0, req_second_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [RegBits-1:0] rsp_overlap_score;
   logic csr_we = 1'b0;
   logic csr_index = CsrThreshIdx;
   logic [RegBits-1:0] csr_wdata = '0;

   typedef logic signed [15:0] coord_type;
   typedef struct {
      coord_type lo [3];
      coord_type hi [3];
   } box_type;

   box_type boxes [256];
   bit written [256];
   logic [RegBits-1:0] thresh_q16, gain_q16;
   logic [RegBits-1:0] score_queue [$];
   int errors = 0;
   int long_hold = 0;

   box_iou_3d_with_containment u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("box_iou_3d_with_containment: mismatch");
      $finish;
   end

   // floor(num * 65536 / den), saturated at one.
   function automatic longint unsigned q16_div(longint unsigned num, longint unsigned den);
      if (num >= den) return 65536;
      return (num << 16) / den;
   endfunction

   function automatic logic [RegBits-1:0] predict_score(box_type a, box_type b);
      longint unsigned inter, va, vb, uni, small_v, iou, cont;
      longint signed lo, hi;
      inter = 1; va = 1; vb = 1;
      for (int k = 0; k < 3; k++) begin
         lo = (a.lo[k] > b.lo[k]) ? a.lo[k] : b.lo[k];
         hi = (a.hi[k] < b.hi[k]) ? a.hi[k] : b.hi[k];
         if (lo >= hi) return '0;
         inter *= longint'(hi - lo);
         va *= longint'(longint'(a.hi[k]) - a.lo[k]);
         vb *= longint'(longint'(b.hi[k]) - b.lo[k]);
      end
      uni = va + vb - inter;
      if (uni == 0) return '0;
      iou = q16_div(inter, uni);
      small_v = (va < vb) ? va : vb;
      if (small_v != 0) begin
         cont = q16_div(inter, small_v);
         if (cont > thresh_q16) iou += (longint'(gain_q16) * (cont - thresh_q16)) >> 16;
      end
      return (iou > 65536) ? OneQ16 : iou[RegBits-1:0];
   endfunction

   // Valid stays up after an item until the next item or an idle period drops it.
   task automatic send_item(bit kind, box_type bx, logic [7:0] slot, logic [7:0] ia,
                            logic [7:0] ib, bit gaps = 1'b1);
      int gap;
      gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17)) : 0;
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_box_slot <= slot;
      req_first_index <= ia;
      req_second_index <= ib;
      req_min_x <= bx.lo[0]; req_min_y <= bx.lo[1]; req_min_z <= bx.lo[2];
      req_max_x <= bx.hi[0]; req_max_y <= bx.hi[1]; req_max_z <= bx.hi[2];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind == KindStore) begin
         boxes[slot] = bx;
         written[slot] = 1'b1;
      end else begin
         score_queue = {score_queue, predict_score(boxes[ia], boxes[ib])};
      end
      @(negedge clock);
   endtask

   task automatic store_box(logic [7:0] slot, box_type bx);
      send_item(KindStore, bx, slot, 8'($urandom), 8'($urandom));
   endtask

   task automatic score_pair(logic [7:0] ia, logic [7:0] ib);
      box_type junk;
      for (int k = 0; k < 3; k++) begin
         junk.lo[k] = coord_type'($urandom);
         junk.hi[k] = coord_type'($urandom);
      end
      send_item(KindScore, junk, 8'($urandom), ia, ib);
   endtask

   function automatic box_type make_box(int cx, int cy, int cz, int sx, int sy, int sz);
      box_type bx;
      bx.lo[0] = coord_type'(cx); bx.lo[1] = coord_type'(cy); bx.lo[2] = coord_type'(cz);
      bx.hi[0] = coord_type'(cx + sx);
      bx.hi[1] = coord_type'(cy + sy);
      bx.hi[2] = coord_type'(cz + sz);
      return bx;
   endfunction

   // Mostly boxes near a common region so that pairs overlap, with some wide noise.
   function automatic box_type rand_box();
      box_type bx;
      int span, base;
      int unsigned mode;
      mode = $urandom_range(0, 9);
      span = (mode < 4) ? 64 : (mode < 8) ? 1024 : 32767;
      for (int k = 0; k < 3; k++) begin
         if (mode == 9) begin
            bx.lo[k] = coord_type'($urandom);
            bx.hi[k] = coord_type'($urandom);
         end else begin
            base = $urandom_range(0, span) - span / 2;
            bx.lo[k] = coord_type'(base);
            bx.hi[k] = coord_type'(base + int'($urandom_range(0, span)));
         end
      end
      return bx;
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (score_queue.size() != 0) @(posedge clock);
      repeat (PipeDepth) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [RegBits-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CsrThreshIdx) thresh_q16 = value;
      else gain_q16 = value;
      @(negedge clock);
   endtask

   task automatic test_directed();
      box_type inv;
      store_box(0, make_box(-32768, -32768, -32768, 65535, 65535, 65535));
      store_box(1, make_box(0, 0, 0, 256, 256, 256));
      store_box(2, make_box(64, 64, 64, 64, 64, 64));
      store_box(3, make_box(256, 0, 0, 256, 256, 256));
      store_box(4, make_box(128, 128, 128, 256, 256, 256));
      inv = make_box(100, 100, 100, 10, 10, 10);
      inv.hi[0] = 0;
      store_box(5, inv);
      store_box(255, make_box(32767, 32767, 32767, 0, 0, 0));
      store_box(6, make_box(-32768, 0, 0, 1, 1, 1));
      score_pair(1, 1);
      score_pair(1, 2);
      score_pair(2, 1);
      score_pair(1, 3);
      score_pair(1, 4);
      score_pair(0, 1);
      score_pair(0, 6);
      score_pair(5, 1);
      score_pair(255, 0);
      score_pair(255, 255);
      score_pair(0, 0);
      wait_idle();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            store_box(8'($urandom), rand_box());
         end else begin
            int ia, ib;
            do ia = $urandom_range(0, 255); while (!written[ia]);
            do ib = $urandom_range(0, 255); while (!written[ib]);
            score_pair(8'(ia), 8'(ib));
         end
      end
   endtask

   task automatic test_backpressure();
      long_hold = 200;
      for (int i = 0; i < 80; i++) begin
         int ia, ib;
         do ia = $urandom_range(0, 255); while (!written[ia]);
         do ib = $urandom_range(0, 255); while (!written[ib]);
         send_item(KindScore, rand_box(), 8'($urandom), 8'(ia), 8'(ib), 1'b0);
      end
      wait_idle();
   endtask

   task automatic test_registers();
      logic [RegBits-1:0] th [5] = '{17'd0, 17'd65536, 17'd131071, 17'd32768, ThreshReset};
      logic [RegBits-1:0] gn [5] = '{17'd65536, 17'd0, 17'd131071, 17'd1, GainReset};
      for (int p = 0; p < 5; p++) begin
         write_reg(CsrThreshIdx, th[p]);
         write_reg(CsrGainIdx, gn[p]);
         test_random(250);
         wait_idle();
      end
   endtask

   // Result receiver with random stalls and one long hold-off on request.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (long_hold) @(negedge clock);
            long_hold = 0;
         end
         stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (score_queue.size() == 0) begin
            $display("%0t: unexpected overlap_score %0d", $time, rsp_overlap_score);
            errors++;
         end else begin
            logic [RegBits-1:0] want;
            want = score_queue.pop_front();
            if (rsp_overlap_score !== want) begin
               $display("%0t: overlap_score expected %0d actual %0d",
                        $time, want, rsp_overlap_score);
               errors++;
            end
         end
      end
   end

   initial begin
      thresh_q16 = ThreshReset;
      gain_q16 = GainReset;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(450);
      wait_idle();
      test_registers();
      if (score_queue.size() != 0) begin
         $display("%0t: %0d overlap scores never arrived", $time, score_queue.size());
         errors++;
      end
      if (errors == 0) $display("box_iou_3d_with_containment: match");
      else $display("box_iou_3d_with_containment: mismatch");
      $finish;
   end
endmodule
